// ===== design/svc_pkg.sv =====
// ----------------------------------------------------------------------------
// svc_pkg
// Shared types and constants of the segment visibility check block.
// ----------------------------------------------------------------------------
`default_nettype none

package svc_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 20;
  localparam int FCOUNT_W    = 7;
  localparam int THRESH_W    = 20;
  localparam int FINDEX_W    = 6;

  localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 7'd0;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FACET_COUNT     = 8'd0,
    REG_SMALL_THRESHOLD = 8'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic issue;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_stall;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/svc_ifs.sv =====
// ----------------------------------------------------------------------------
// svc_ifs
// Channel interfaces: segment items, visibility results, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface svc_in_if #(
  parameter int COORD_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [svc_pkg::FINDEX_W-1:0]        facet_index;
  logic signed [COORD_BITS-1:0]        start_x;
  logic signed [COORD_BITS-1:0]        start_y;
  logic signed [COORD_BITS-1:0]        end_x;
  logic signed [COORD_BITS-1:0]        end_y;

  modport source (
    output valid, mode, facet_index, start_x, start_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, mode, facet_index, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

interface svc_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

interface svc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [svc_pkg::CFG_INDEX_W-1:0]  index;
  logic [svc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/svc_ram.sv =====
// ----------------------------------------------------------------------------
// svc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output      logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/svc_ctrl.sv =====
// ----------------------------------------------------------------------------
// svc_ctrl
// Sequencer: takes transactions, walks the facet table, hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_ctrl #(
  parameter int MAX_FACETS = 64,
  localparam int AW        = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  input  wire logic                              in_mode,
  output      logic                              in_ready,
  input  wire logic                              cfg_valid,
  input  wire logic [svc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [svc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire svc_pkg::dp_status_t               status,
  output      svc_pkg::ctrl_cmd_t                cmd,
  output      logic [AW-1:0]                     issue_addr
);

  localparam int CW_RAW = $clog2(MAX_FACETS + 1);
  localparam int CW     = (CW_RAW > svc_pkg::FCOUNT_W) ? CW_RAW : svc_pkg::FCOUNT_W;

  svc_pkg::state_t                state;
  svc_pkg::state_t                state_next;
  logic [svc_pkg::FCOUNT_W-1:0]   facet_count;
  logic [CW-1:0]                  limit;
  logic [CW-1:0]                  idx;
  logic [CW-1:0]                  idx_inc;
  logic [CW-1:0]                  fc_ext;
  logic [CW-1:0]                  lim_now;
  logic                           in_acc;
  logic                           is_query;

  assign fc_ext   = CW'(facet_count);
  assign lim_now  = (fc_ext > CW'(MAX_FACETS)) ? CW'(MAX_FACETS) : fc_ext;
  assign idx_inc  = idx + CW'(1);
  assign in_acc   = in_valid && in_ready;
  assign is_query = (in_mode == svc_pkg::MODE_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= svc_pkg::ST_IDLE;
      facet_count <= svc_pkg::FCOUNT_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_index == svc_pkg::REG_FACET_COUNT) begin
        facet_count <= cfg_data[svc_pkg::FCOUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx   <= '0;
      limit <= lim_now;
    end else if (cmd.issue) begin
      idx <= idx_inc;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      svc_pkg::ST_IDLE: begin
        if (in_acc && is_query) begin
          state_next = (lim_now == '0) ? svc_pkg::ST_DONE : svc_pkg::ST_SCAN;
        end
      end
      svc_pkg::ST_SCAN: begin
        if (idx_inc == limit) begin
          state_next = svc_pkg::ST_DRAIN;
        end
      end
      svc_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = svc_pkg::ST_DONE;
        end
      end
      svc_pkg::ST_DONE: begin
        if (!status.out_stall) begin
          state_next = svc_pkg::ST_IDLE;
        end
      end
      default: state_next = svc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == svc_pkg::ST_IDLE);
    cmd.capture = in_acc && is_query;
    cmd.write   = in_acc && !is_query;
    cmd.issue   = (state == svc_pkg::ST_SCAN);
    cmd.publish = (state == svc_pkg::ST_DONE) && !status.out_stall;
    issue_addr  = idx[AW-1:0];
  end

endmodule

`default_nettype wire

// ===== design/svc_dp.sv =====
// ----------------------------------------------------------------------------
// svc_dp
// Datapath: facet table, four-stage cross product pipeline, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_dp #(
  parameter int MAX_FACETS = 64,
  parameter int COORD_BITS = 16,
  localparam int AW        = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire svc_pkg::ctrl_cmd_t                cmd,
  input  wire logic [AW-1:0]                     issue_addr,
  output      svc_pkg::dp_status_t               status,
  input  wire logic [svc_pkg::FINDEX_W-1:0]      facet_index,
  input  wire logic signed [COORD_BITS-1:0]      start_x,
  input  wire logic signed [COORD_BITS-1:0]      start_y,
  input  wire logic signed [COORD_BITS-1:0]      end_x,
  input  wire logic signed [COORD_BITS-1:0]      end_y,
  input  wire logic                              cfg_valid,
  input  wire logic [svc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [svc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic                              out_visible
);

  localparam int CB     = COORD_BITS;
  localparam int DW     = CB + 1;
  localparam int PW     = 2 * DW;
  localparam int XW_RAW = PW + 1;
  localparam int XW     = (XW_RAW > svc_pkg::THRESH_W + 2) ? XW_RAW : svc_pkg::THRESH_W + 2;

  logic [svc_pkg::THRESH_W-1:0] threshold;
  logic signed [XW-1:0]         thr_pos;
  logic signed [XW-1:0]         thr_neg;

  logic [31:0]                  fi_ext;
  logic                         wr_en;
  logic [AW-1:0]                waddr;
  logic [4*CB-1:0]              rdata;

  logic signed [CB-1:0]         ax, ay, bx, by;
  logic signed [DW-1:0]         d1x, d1y;
  logic signed [CB-1:0]         px, py, qx, qy;

  logic                         v1, v2, v3, v4;
  logic signed [DW-1:0]         d2x, d2y, pax, pay, qax, qay, bpx, bpy;
  logic signed [PW-1:0]         m [10];
  logic signed [XW-1:0]         c [5];
  logic                         flip;
  logic [3:0]                   side_ok;
  logic                         hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= svc_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_index == svc_pkg::REG_SMALL_THRESHOLD) begin
      threshold <= cfg_data[svc_pkg::THRESH_W-1:0];
    end
  end

  assign thr_pos = $signed({{(XW - svc_pkg::THRESH_W){1'b0}}, threshold});
  assign thr_neg = -thr_pos;

  assign fi_ext = 32'(facet_index);
  assign wr_en  = cmd.write && (fi_ext < 32'(MAX_FACETS));
  assign waddr  = fi_ext[AW-1:0];

  svc_ram #(
    .WIDTH (4 * CB),
    .DEPTH (MAX_FACETS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata ({start_x, start_y, end_x, end_y}),
    .re    (cmd.issue),
    .raddr (issue_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ax  <= start_x;
      ay  <= start_y;
      bx  <= end_x;
      by  <= end_y;
      d1x <= {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
      d1y <= {end_y[CB-1], end_y} - {start_y[CB-1], start_y};
    end
  end

  assign px = rdata[4*CB-1:3*CB];
  assign py = rdata[3*CB-1:2*CB];
  assign qx = rdata[2*CB-1:CB];
  assign qy = rdata[CB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    d2x <= {qx[CB-1], qx} - {px[CB-1], px};
    d2y <= {qy[CB-1], qy} - {py[CB-1], py};
    pax <= {px[CB-1], px} - {ax[CB-1], ax};
    pay <= {py[CB-1], py} - {ay[CB-1], ay};
    qax <= {qx[CB-1], qx} - {ax[CB-1], ax};
    qay <= {qy[CB-1], qy} - {ay[CB-1], ay};
    bpx <= {bx[CB-1], bx} - {px[CB-1], px};
    bpy <= {by[CB-1], by} - {py[CB-1], py};
  end

  always_ff @(posedge clk) begin
    m[0] <= d1x * d2y;
    m[1] <= d1y * d2x;
    m[2] <= pax * d1y;
    m[3] <= pay * d1x;
    m[4] <= d1x * qay;
    m[5] <= d1y * qax;
    m[6] <= bpx * d2y;
    m[7] <= bpy * d2x;
    m[8] <= d2y * pax;
    m[9] <= d2x * pay;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 5; k++) begin
      c[k] <= XW'(m[2*k]) - XW'(m[2*k+1]);
    end
  end

  always_comb begin
    flip = (c[0] < thr_pos);
    for (int k = 0; k < 4; k++) begin
      side_ok[k] = flip ? (c[k+1] <= thr_neg) : (c[k+1] >= thr_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit <= 1'b0;
    end else if (v4 && (&side_ok)) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_visible <= !hit;
    end
  end

  assign status.pipe_busy = v1 || v2 || v3 || v4;
  assign status.out_stall = out_valid && !out_ready;

endmodule

`default_nettype wire

// ===== design/segment_visibility_check_core.sv =====
// ----------------------------------------------------------------------------
// segment_visibility_check_core
// Tests a path segment against a table of loaded cutting segments.
// ----------------------------------------------------------------------------
// A load transaction (mode 0) writes one cutting segment into its table slot
// and returns nothing; a slot at or above MAX_FACETS is dropped. A query
// transaction (mode 1) returns one result, visible=1 unless the path strictly
// crosses one of the first facet_count slots. A query reads one table entry
// per cycle through the RAM read port into a four-stage cross product
// pipeline; it occupies the block for all N entries, N being facet_count
// capped at MAX_FACETS, until the pipeline drains and for any time the result
// register waits on the sink. One query is in work at a time; the next
// transaction is taken once the result moves to the output register. Slots
// never loaded read back as undefined. Register writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_visibility_check_core #(
  parameter int MAX_FACETS = 64,
  parameter int COORD_BITS = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  svc_in_if.sink    in_ch,
  svc_out_if.source out_ch,
  svc_cfg_if.sink   cfg
);

  localparam int AW = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1;

  svc_pkg::ctrl_cmd_t  cmd;
  svc_pkg::dp_status_t status;
  logic [AW-1:0]       issue_addr;

  assign cfg.ready = 1'b1;

  svc_ctrl #(
    .MAX_FACETS (MAX_FACETS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_mode    (in_ch.mode),
    .in_ready   (in_ch.ready),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .status     (status),
    .cmd        (cmd),
    .issue_addr (issue_addr)
  );

  svc_dp #(
    .MAX_FACETS (MAX_FACETS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .issue_addr  (issue_addr),
    .status      (status),
    .facet_index (in_ch.facet_index),
    .start_x     (in_ch.start_x),
    .start_y     (in_ch.start_y),
    .end_x       (in_ch.end_x),
    .end_y       (in_ch.end_y),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_visible (out_ch.visible)
  );

endmodule

`default_nettype wire
